// ===== src/turning_grille_decipher_defines.svh =====
// Assertion helpers for the turning grille decipher checker.
`ifndef TURNING_GRILLE_DECIPHER_DEFINES_SVH
`define TURNING_GRILLE_DECIPHER_DEFINES_SVH

// checked only while out of reset
`define TGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TGD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tgd_pkg.sv =====
package tgd_pkg;

  localparam int unsigned SIDE_W     = 5;
  localparam int unsigned ORI_W      = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned TURN_W     = 3;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_HOLE   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_LETTER = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_ALT      = 3'd1,
    ST_BAD      = 3'd2,
    ST_CLEARED  = 3'd3,
    ST_PLACED   = 3'd4,
    ST_DROPPED  = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  localparam logic [ORI_W-1:0]  ORI_TURN1  = 3'd1;
  localparam logic [ORI_W-1:0]  ORI_TURN2  = 3'd2;
  localparam logic [ORI_W-1:0]  ORI_TURN3  = 3'd3;
  localparam logic [ORI_W-1:0]  ORI_TURN4  = 3'd4;
  localparam logic [TURN_W-1:0] TURN_BLANK = 3'd0;
  localparam logic [TURN_W-1:0] TURN_FIRST = 3'd1;
  localparam logic [TURN_W-1:0] TURN_LAST  = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic hole_rd;
    logic hole_eval;
    logic hole_wr;
    logic letter_eval;
    logic sweep_step;
    logic res_bad;
    logic res_clear;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_done;
    logic hole_bad;
    logic wr_last;
  } stat_t;

endpackage

// ===== src/tgd_ctrl.sv =====
module tgd_ctrl
  import tgd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic [OP_W-1:0] in_op,
  input  logic            cfg_we,
  input  logic            out_tready,
  input  stat_t           stat,
  output cmd_t            cmd,
  output logic            in_tready,
  output logic            out_tvalid
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_HRD,
    S_HEV,
    S_HWR,
    S_LEV,
    S_FIN
  } state_t;

  state_t state_r;
  logic   reply_r;
  logic   out_valid_r;
  logic   accept;
  logic   out_free;
  op_t    op;

  assign op         = op_t'(in_op);
  assign in_tready  = (state_r == S_IDLE) && !cfg_we;
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd             = '0;
    cmd.capture     = accept;
    cmd.hole_rd     = (state_r == S_HRD);
    cmd.hole_eval   = (state_r == S_HEV);
    cmd.hole_wr     = (state_r == S_HWR);
    cmd.letter_eval = (state_r == S_LEV);
    cmd.sweep_step  = (state_r == S_SWEEP) && !cfg_we;
    cmd.res_clear   = (state_r == S_SWEEP) && stat.sweep_done && reply_r;
    cmd.out_load    = (state_r == S_FIN) && out_free;
    cmd.res_bad     = (state_r == S_HRD) && stat.hole_bad;
    if (accept && (op != OP_HOLE) && (op != OP_CLEAR) && (op != OP_LETTER)) begin
      cmd.res_bad = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        state_r <= S_SWEEP;
        reply_r <= 1'b0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (accept) begin
              unique case (op)
                OP_HOLE:   state_r <= S_HRD;
                OP_CLEAR: begin
                  state_r <= S_SWEEP;
                  reply_r <= 1'b1;
                end
                OP_LETTER: state_r <= S_LEV;
                default:   state_r <= S_FIN;
              endcase
            end
          end
          S_SWEEP: begin
            if (stat.sweep_done) begin
              state_r <= reply_r ? S_FIN : S_IDLE;
              reply_r <= 1'b0;
            end
          end
          S_HRD:   state_r <= stat.hole_bad ? S_FIN : S_HEV;
          S_HEV:   state_r <= S_HWR;
          S_HWR: begin
            if (stat.wr_last) state_r <= S_FIN;
          end
          S_LEV:   state_r <= S_FIN;
          S_FIN: begin
            if (out_free) state_r <= S_IDLE;
          end
          default: state_r <= S_SWEEP;
        endcase
      end
    end
  end

endmodule

// ===== src/tgd_dp.sv =====
module tgd_dp
  import tgd_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_we,
  input  logic [SIDE_W-1:0]     cfg_wdata,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]            out_tuser,
  output logic                  out_tlast
);

  localparam int unsigned DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned EMAX     = (MAX_SIDE > 31) ? 31 : MAX_SIDE;
  localparam int unsigned LW       = $clog2(EMAX * EMAX + 1);
  localparam int unsigned RST_SIDE = (MAX_SIDE < 4) ? MAX_SIDE : 4;
  localparam int unsigned RST_L    = RST_SIDE * RST_SIDE;
  localparam int unsigned RST_Q    = RST_L / 4;

  function automatic logic [AW-1:0] cell_addr(input logic [SIDE_W-1:0] r,
                                              input logic [SIDE_W-1:0] c);
    cell_addr = AW'(r * MAX_SIDE + c);
  endfunction

  // key table
  logic [TURN_W-1:0] mem [DEPTH];

  // captured item
  logic [SIDE_W-1:0] row_r, col_r;
  logic [ORI_W-1:0]  ori_r;
  logic [BYTE_W-1:0] let_r;

  // side, length, letter position and quarter pointers
  logic [SIDE_W-1:0] n_r;
  logic [LW-1:0]     len_r;
  logic [LW-1:0]     cnt_r;
  logic [SIDE_W-1:0] crow_r, ccol_r;
  logic [LW-1:0]     qp_r [4];

  logic [AW-1:0]     sweep_r;
  logic [TURN_W-1:0] rd_a_r, rd_b_r;
  logic [SIDE_W-1:0] cur_row_r, cur_col_r;
  logic [1:0]        step_r;
  logic              clr_r;

  status_t           res_status_r, out_status_r;
  logic [BYTE_W-1:0] res_pos_r, res_let_r, out_pos_r, out_let_r;
  logic              res_end_r, out_end_r;

  // configuration decode
  logic [6:0]          cfg_wide;
  logic [SIDE_W-1:0]   n_cfg;
  logic [2*SIDE_W-1:0] sq_cfg;
  logic [LW-1:0]       len_cfg;
  logic [LW-1:0]       q_src;
  logic [LW-1:0]       qload [4];

  assign cfg_wide = {2'b00, cfg_wdata};
  assign n_cfg    = (cfg_wdata < SIDE_W'(2)) ? SIDE_W'(2) :
                    (cfg_wide > 7'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg_wdata;
  assign sq_cfg   = (2*SIDE_W)'(n_cfg) * (2*SIDE_W)'(n_cfg);
  assign len_cfg  = LW'(sq_cfg);
  assign q_src    = cfg_we ? (len_cfg >> 2) : (len_r >> 2);
  assign qload[0] = '0;
  assign qload[1] = q_src;
  assign qload[2] = q_src << 1;
  assign qload[3] = q_src + (q_src << 1);

  // hole geometry
  logic [SIDE_W-1:0] m, r0, c0, rot_r, rot_c, mid, mid1;

  assign m    = n_r - SIDE_W'(1);
  assign r0   = row_r - SIDE_W'(1);
  assign c0   = col_r - SIDE_W'(1);
  assign mid  = n_r >> 1;
  assign mid1 = mid + SIDE_W'(1);

  always_comb begin
    case (ori_r)
      ORI_TURN2: begin rot_r = m - c0; rot_c = r0;     end
      ORI_TURN3: begin rot_r = m - r0; rot_c = m - c0; end
      ORI_TURN4: begin rot_r = c0;     rot_c = m - r0; end
      default:   begin rot_r = r0;     rot_c = c0;     end
    endcase
  end

  assign stat.hole_bad = (row_r == '0) || (row_r > n_r) || (col_r == '0) ||
                         (col_r > n_r) || (ori_r < ORI_TURN1) || (ori_r > ORI_TURN4) ||
                         (n_r[0] && (row_r == mid1) && (col_r == mid1));
  assign stat.wr_last    = (step_r == 2'd3);
  assign stat.sweep_done = (sweep_r == AW'(DEPTH - 1));

  // table ports
  logic [AW-1:0]     ra, rb, wa;
  logic              we;
  logic [TURN_W-1:0] wd;

  assign ra = cmd.hole_rd ? cell_addr(r0, c0) : cell_addr(crow_r, ccol_r);
  assign rb = cell_addr(rot_r, rot_c);
  assign we = cmd.sweep_step || cmd.hole_wr;
  assign wa = cmd.hole_wr ? cell_addr(cur_row_r, cur_col_r) : sweep_r;
  assign wd = (cmd.hole_wr && !clr_r) ? TURN_W'(step_r) + TURN_FIRST : TURN_BLANK;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  // letter evaluation
  logic [LW-1:0]     limit, ptr;
  logic [1:0]        kidx;
  logic              centre, blank, full, last;

  assign limit  = len_r[0] ? len_r - LW'(1) : len_r;
  assign kidx   = 2'(rd_a_r - TURN_FIRST);
  assign ptr    = qp_r[kidx];
  assign centre = n_r[0] && (crow_r == mid) && (ccol_r == mid);
  assign blank  = (rd_a_r < TURN_FIRST) || (rd_a_r > TURN_LAST);
  assign full   = (ptr >= limit);
  assign last   = (cnt_r == len_r - LW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cfg_we) begin
      sweep_r <= '0;
    end else if (cmd.sweep_step) begin
      sweep_r <= stat.sweep_done ? '0 : sweep_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= SIDE_W'(RST_SIDE);
      len_r   <= LW'(RST_L);
      cnt_r   <= '0;
      crow_r  <= '0;
      ccol_r  <= '0;
      qp_r[0] <= '0;
      qp_r[1] <= LW'(RST_Q);
      qp_r[2] <= LW'(2 * RST_Q);
      qp_r[3] <= LW'(3 * RST_Q);
    end else if (cfg_we) begin
      n_r    <= n_cfg;
      len_r  <= len_cfg;
      cnt_r  <= '0;
      crow_r <= '0;
      ccol_r <= '0;
      qp_r   <= qload;
    end else if (cmd.letter_eval) begin
      if (last) begin
        cnt_r  <= '0;
        crow_r <= '0;
        ccol_r <= '0;
        qp_r   <= qload;
      end else begin
        cnt_r <= cnt_r + LW'(1);
        if (ccol_r == m) begin
          ccol_r <= '0;
          crow_r <= crow_r + SIDE_W'(1);
        end else begin
          ccol_r <= ccol_r + SIDE_W'(1);
        end
        if (!centre && !blank && !full) qp_r[kidx] <= ptr + LW'(1);
      end
    end
  end

  // item capture, hole walk and result staging
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_tdata[4:0];
      col_r <= in_tdata[9:5];
      ori_r <= in_tdata[12:10];
      let_r <= in_tdata[20:13];
    end

    if (cmd.hole_rd) begin
      cur_row_r <= rot_r;
      cur_col_r <= rot_c;
    end else if (cmd.hole_wr) begin
      // step to the next quarter turn of the same hole
      cur_row_r <= cur_col_r;
      cur_col_r <= m - cur_row_r;
      step_r    <= step_r + 2'd1;
    end

    if (cmd.hole_eval) begin
      clr_r  <= (rd_b_r == TURN_FIRST);
      step_r <= 2'd0;
    end

    if (cmd.res_bad || cmd.res_clear || cmd.hole_eval) begin
      res_pos_r <= '0;
      res_let_r <= '0;
      res_end_r <= 1'b0;
      if (cmd.res_bad)        res_status_r <= ST_BAD;
      else if (cmd.res_clear) res_status_r <= ST_CLEARED;
      else                    res_status_r <= (rd_a_r != TURN_BLANK) ? ST_ALT : ST_NEW;
    end else if (cmd.letter_eval) begin
      res_end_r <= last;
      res_pos_r <= '0;
      res_let_r <= '0;
      if (centre) begin
        res_status_r <= ST_PLACED;
        res_pos_r    <= BYTE_W'(len_r - LW'(1));
        res_let_r    <= let_r;
      end else if (blank) begin
        res_status_r <= ST_DROPPED;
      end else if (full) begin
        res_status_r <= ST_OVERFLOW;
      end else begin
        res_status_r <= ST_PLACED;
        res_pos_r    <= BYTE_W'(ptr);
        res_let_r    <= let_r;
      end
    end

    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_pos_r    <= res_pos_r;
      out_let_r    <= res_let_r;
      out_end_r    <= res_end_r;
    end
  end

  assign out_tdata = {out_let_r, out_pos_r};
  assign out_tuser = out_status_r;
  assign out_tlast = out_end_r;

endmodule

// ===== src/turning_grille_decipher.sv =====
// Channel   Dir  tdata (low bit up)                        tuser       tlast
// in_       in   row[4:0] column[9:5] orientation[12:10]   op[1:0]     -
//                letter[20:13], zero fill to 24
// out_      out  plain_position[7:0] plain_letter[15:8]    status[2:0] block_end
// cfg_      in   cfg_wdata = grid_side[4:0], written when cfg_we is high
//
// Letter item: table lookup, pointer update, result load.
// Hole item: paced by the four single-port writes of the rotated cells.
// Clear item: the whole table is swept, one table entry cleared per cycle while cfg_we is low.
// After reset and after every cfg write the table is swept the same way
// with in_tready low.
// A result waits in the output register; a new item is taken meanwhile.
module turning_grille_decipher
  import tgd_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // row, column, orientation, letter
  input  logic [OP_W-1:0]       in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // plain_position, plain_letter
  output logic [2:0]            out_tuser,  // status
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [SIDE_W-1:0]     cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  tgd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .cfg_we     (cfg_we),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  tgd_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// ===== src/tgd_checker.sv =====
`include "turning_grille_decipher_defines.svh"

module tgd_checker
  import tgd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [OP_W-1:0]       in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]            out_tuser,
  input logic                  out_tlast,
  input logic                  cfg_we,
  input logic [SIDE_W-1:0]     cfg_wdata
);

  `TGD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  `TGD_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid, "result shown straight after reset")

  // a register write starts a table sweep, so no item is taken next cycle
  `TGD_ASSERT(a_cfg_sweep, cfg_we |=> !in_tready, "item taken during post-config sweep")

  // only letter results close a block
  `TGD_ASSERT(a_last_letter, out_tvalid && out_tlast |-> (out_tuser == ST_PLACED) || (out_tuser == ST_DROPPED) || (out_tuser == ST_OVERFLOW), "block end on a non-letter result")

endmodule

bind turning_grille_decipher tgd_checker u_tgd_checker (.*);
